// ----- rtl/core/rfit_pkg.sv -----
// ----------------------------------------------------------------------------
// rfit_pkg
// Shared constants, types and helpers of the receive ring buffer with idle
// timeout.
// ----------------------------------------------------------------------------
package rfit_pkg;

  // Buffer geometry.
  localparam int unsigned DEPTH = 256;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  // Width used to compare the fill count against the 8-bit near-full level.
  localparam int unsigned CMP_W = (PTR_W > 8) ? PTR_W : 8;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_FULL  = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [7:0] IDLE_LIMIT_RST = 8'd10;
  localparam logic [7:0] NEAR_FULL_RST  = 8'd192;

  // Idle counter value at which the timer stops on its own.
  localparam logic [7:0] IDLE_STOP = 8'hFF;
  // Largest fill count that the result can report.
  localparam logic [7:0] FILL_MAX = 8'hFF;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_RX   = 2'd0,
    KIND_TICK = 2'd1,
    KIND_POP  = 2'd2
  } kind_e;

  // Notify causes.
  localparam logic CAUSE_NEAR_FULL = 1'b0;
  localparam logic CAUSE_IDLE      = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;

  // Next ring position, wrapping at DEPTH.
  function automatic ptr_t ptr_adv(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Number of bytes between the read and write positions.
  function automatic ptr_t ptr_fill(input ptr_t w, input ptr_t r);
    ptr_t f;
    if (w < r) begin
      f = PTR_W'({1'b0, w} + (PTR_W + 1)'(DEPTH) - {1'b0, r});
    end else begin
      f = w - r;
    end
    return f;
  endfunction

endpackage

// ----- rtl/core/rx_fifo_with_idle_timeout.sv -----
// ----------------------------------------------------------------------------
// rx_fifo_with_idle_timeout
// Receive ring buffer for a serial port with near-full and idle-timeout
// notification.
// ----------------------------------------------------------------------------
// Each word on the input channel is a received byte, an idle timer tick or a
// pop, and yields exactly one result word. The block takes one word per clock
// cycle: pointers, idle timer and flags update at the accepting edge, and a
// pop reads the byte store (a RAM with one write and one registered read
// port) at that edge, so the popped byte arrives together with the result.
// A new word is accepted while the previous result is being taken; a result
// that is not taken stalls the input. The byte store needs no clearing
// after reset, since a pop only reads entries written before.
// An overrun empties the buffer and sets a sticky overflow flag that only
// reset clears. Configuration registers should be written while idle.
module rx_fifo_with_idle_timeout (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [rfit_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rfit_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [7:0]                     rx_byte_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     read_data_o,
  output logic                           read_valid_o,
  output logic [7:0]                     fill_count_o,
  output logic                           overflow_o,
  output logic                           notify_o,
  output logic                           notify_cause_o
);

  import rfit_pkg::*;

  // Configuration.
  logic [7:0] idle_limit_q;
  logic [7:0] near_full_q;

  // Buffer and timer state.
  ptr_t       wr_ptr_q, wr_ptr_d;
  ptr_t       rd_ptr_q, rd_ptr_d;
  logic [7:0] idle_cnt_q, idle_cnt_d;
  logic       idle_run_q, idle_run_d;
  logic       ovf_q, ovf_d;

  // Result register.
  logic       out_valid_q;
  logic       res_valid_q, res_valid_d;
  logic [7:0] res_fill_q, res_fill_d;
  logic       res_note_q, res_note_d;
  logic       res_cause_q, res_cause_d;

  logic       in_fire;
  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rdata;
  ptr_t       wr_next;
  ptr_t       fill;
  logic [CMP_W-1:0] fill_cmp;
  logic       overrun;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign wr_next = ptr_adv(wr_ptr_q);
  assign overrun = (wr_next == rd_ptr_q);

  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    idle_cnt_d  = idle_cnt_q;
    idle_run_d  = idle_run_q;
    ovf_d       = ovf_q;
    res_valid_d = 1'b0;
    res_note_d  = 1'b0;
    res_cause_d = CAUSE_NEAR_FULL;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    unique case (kind_e'(kind_i))
      KIND_RX: begin
        ram_we     = in_fire;
        idle_cnt_d = '0;
        idle_run_d = 1'b1;
        if (overrun) begin
          wr_ptr_d = '0;
          rd_ptr_d = '0;
          ovf_d    = 1'b1;
        end else begin
          wr_ptr_d = wr_next;
        end
      end
      KIND_TICK: begin
        if (idle_run_q) begin
          idle_cnt_d = idle_cnt_q + 8'd1;
          if (idle_cnt_d == idle_limit_q) begin
            res_note_d  = 1'b1;
            res_cause_d = CAUSE_IDLE;
            idle_run_d  = 1'b0;
          end else if (idle_cnt_d == IDLE_STOP) begin
            idle_run_d = 1'b0;
          end
        end
      end
      KIND_POP: begin
        if (wr_ptr_q != rd_ptr_q) begin
          ram_re      = in_fire;
          res_valid_d = 1'b1;
          rd_ptr_d    = ptr_adv(rd_ptr_q);
        end
      end
      default: begin
      end
    endcase

    fill     = ptr_fill(wr_ptr_d, rd_ptr_d);
    fill_cmp = CMP_W'(fill);
    // The near-full check compares the full count, before saturation.
    if ((kind_e'(kind_i) == KIND_RX) && (fill_cmp == CMP_W'(near_full_q))) begin
      res_note_d  = 1'b1;
      res_cause_d = CAUSE_NEAR_FULL;
    end
    if (fill_cmp > CMP_W'(FILL_MAX)) begin
      res_fill_d = FILL_MAX;
    end else begin
      res_fill_d = fill_cmp[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= IDLE_LIMIT_RST;
      near_full_q  <= NEAR_FULL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IDLE_LIMIT: idle_limit_q <= cfg_wdata_i[7:0];
        REG_NEAR_FULL:  near_full_q  <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      idle_cnt_q  <= '0;
      idle_run_q  <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        wr_ptr_q   <= wr_ptr_d;
        rd_ptr_q   <= rd_ptr_d;
        idle_cnt_q <= idle_cnt_d;
        idle_run_q <= idle_run_d;
        ovf_q      <= ovf_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_valid_q <= res_valid_d;
      res_fill_q  <= res_fill_d;
      res_note_q  <= res_note_d;
      res_cause_q <= res_cause_d;
    end
  end

  rfit_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = res_valid_q ? ram_rdata : 8'd0;
  assign read_valid_o   = res_valid_q;
  assign fill_count_o   = res_fill_q;
  // The overflow flag changes only at an accepting edge, where any waiting
  // result is taken as well, so it can be read directly from the state
  // register.
  assign overflow_o     = ovf_q;
  assign notify_o       = res_note_q;
  assign notify_cause_o = res_cause_q;

  // An overrun leaves both pointers at the start and the flag set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (kind_e'(kind_i) == KIND_RX) && overrun) |=>
      (wr_ptr_q == '0) && (rd_ptr_q == '0) && ovf_q)
    else $error("overrun did not reset the pointers");

  // The overflow flag never falls outside reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  // The store is never written and read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store written and read together");

  // A successful pop never carries a notify.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_valid_q) |-> !res_note_q)
    else $error("pop result carries a notify");

  // An idle-timeout notify always stops the timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_note_d && (res_cause_d == CAUSE_IDLE)) |=> !idle_run_q)
    else $error("idle timer still running after timeout");

endmodule

// ----- rtl/core/rfit_ram.sv -----
// ----------------------------------------------------------------------------
// rfit_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
module rfit_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
